// ===== design/spdt_pkg.sv =====
package spdt_pkg;

	localparam int DESC_W = 16;
	localparam int MASK_W = 16;
	localparam int IDX_W = 6;
	localparam int COUNT_W = 7;

	localparam logic [MASK_W-1:0] FORCED_BITS = 16'h0038;

	typedef enum logic [1:0] {
		OP_ACTIVATE   = 2'd0,
		OP_DEACTIVATE = 2'd1,
		OP_CLEAR      = 2'd2,
		OP_READ       = 2'd3
	} op_t;

	typedef struct packed {
		op_t               operation;
		logic [DESC_W-1:0] descriptor;
		logic [MASK_W-1:0] event_mask;
		logic              merge;
		logic [IDX_W-1:0]  read_index;
	} req_t;

	typedef struct packed {
		logic               changed;
		logic               table_full;
		logic [COUNT_W-1:0] active_count;
		logic               entry_valid;
		logic [DESC_W-1:0]  entry_descriptor;
		logic [MASK_W-1:0]  entry_events;
	} rsp_t;

	typedef struct packed {
		logic [DESC_W-1:0] descriptor;
		logic [MASK_W-1:0] events;
	} slot_t;

	typedef enum logic [1:0] {
		RD_PTR,
		RD_PTR_DEC,
		RD_PTR_INC,
		RD_IDX
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_SHIFT,
		WR_NEW,
		WR_EVENTS
	} wr_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_NOTFOUND,
		ST_FOUND,
		ST_INS_CHK,
		ST_INS_MV,
		ST_REM_CHK,
		ST_REM_MV,
		ST_READ_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic    load;
		logic    ptr_zero;
		logic    ptr_inc;
		logic    ptr_dec;
		logic    ptr_from_count;
		logic    ptr_from_pos;
		logic    pos_from_ptr;
		logic    pos_from_count;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    count_inc;
		logic    count_dec;
		logic    count_clear;
		logic    res_set;
		logic    res_changed;
		logic    res_full;
		logic    res_valid;
		logic    push;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic mask_zero;
		logic merge;
		logic count_zero;
		logic count_full;
		logic ptr_last;
		logic ptr_gt_pos;
		logic hit_lt;
		logic hit_eq;
		logic read_ok;
		logic upd_same;
		logic upd_drop;
	} sts_t;

endpackage

// ===== design/spdt_dp.sv =====
module spdt_dp #(
	parameter int CAPACITY = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  spdt_pkg::cmd_t   cmd,
	input  spdt_pkg::req_t   req_data,
	output spdt_pkg::sts_t   sts,
	output spdt_pkg::rsp_t   rsp_data
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > spdt_pkg::IDX_W) ? CW : spdt_pkg::IDX_W;

	spdt_pkg::slot_t mem [CAPACITY];

	spdt_pkg::req_t  item_q;
	spdt_pkg::slot_t rdata_q;
	spdt_pkg::rsp_t  rsp_q;
	logic [IW-1:0]   ptr_q;
	logic [CW-1:0]   pos_q;
	logic [CW-1:0]   count_q;
	logic            res_changed_q;
	logic            res_full_q;
	logic            res_valid_q;

	logic [IW-1:0]                 rd_addr;
	logic [IW-1:0]                 wr_addr;
	spdt_pkg::slot_t               wr_data;
	logic [spdt_pkg::MASK_W-1:0]   ev_act;
	logic [spdt_pkg::MASK_W-1:0]   upd;

	always_comb begin
		ev_act = item_q.event_mask | spdt_pkg::FORCED_BITS;
		if (item_q.operation == spdt_pkg::OP_ACTIVATE) begin
			if (item_q.event_mask == '0) begin
				upd = '0;
			end else if (item_q.merge) begin
				upd = rdata_q.events | ev_act;
			end else begin
				upd = ev_act;
			end
		end else begin
			upd = rdata_q.events & ~item_q.event_mask;
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			spdt_pkg::RD_PTR:     rd_addr = ptr_q;
			spdt_pkg::RD_PTR_DEC: rd_addr = ptr_q - IW'(1);
			spdt_pkg::RD_PTR_INC: rd_addr = ptr_q + IW'(1);
			spdt_pkg::RD_IDX:     rd_addr = IW'(item_q.read_index);
			default:              rd_addr = ptr_q;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			spdt_pkg::WR_SHIFT: begin
				wr_addr = ptr_q;
				wr_data = rdata_q;
			end
			spdt_pkg::WR_NEW: begin
				wr_addr = IW'(pos_q);
				wr_data = '{descriptor: item_q.descriptor, events: ev_act};
			end
			spdt_pkg::WR_EVENTS: begin
				wr_addr = IW'(pos_q);
				wr_data = '{descriptor: item_q.descriptor, events: upd};
			end
			default: begin
				wr_addr = ptr_q;
				wr_data = rdata_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.count_clear) begin
			count_q <= '0;
		end else if (cmd.count_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.count_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req_data;
		end
		if (cmd.ptr_zero) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + IW'(1);
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - IW'(1);
		end else if (cmd.ptr_from_count) begin
			ptr_q <= IW'(count_q);
		end else if (cmd.ptr_from_pos) begin
			ptr_q <= IW'(pos_q);
		end
		if (cmd.pos_from_ptr) begin
			pos_q <= CW'(ptr_q);
		end else if (cmd.pos_from_count) begin
			pos_q <= count_q;
		end
		if (cmd.res_set) begin
			res_changed_q <= cmd.res_changed;
			res_full_q <= cmd.res_full;
			res_valid_q <= cmd.res_valid;
		end
		if (cmd.push) begin
			rsp_q.changed <= res_changed_q;
			rsp_q.table_full <= res_full_q;
			rsp_q.active_count <= spdt_pkg::COUNT_W'(count_q);
			rsp_q.entry_valid <= res_valid_q;
			rsp_q.entry_descriptor <= res_valid_q ? rdata_q.descriptor : '0;
			rsp_q.entry_events <= res_valid_q ? rdata_q.events : '0;
		end
	end

	always_comb begin
		sts.op = item_q.operation;
		sts.mask_zero = (item_q.event_mask == '0);
		sts.merge = item_q.merge;
		sts.count_zero = (count_q == '0);
		sts.count_full = (count_q == CW'(CAPACITY));
		sts.ptr_last = ((CW'(ptr_q) + CW'(1)) == count_q);
		sts.ptr_gt_pos = (CW'(ptr_q) > pos_q);
		sts.hit_lt = (rdata_q.descriptor < item_q.descriptor);
		sts.hit_eq = (rdata_q.descriptor == item_q.descriptor);
		sts.read_ok = (CMPW'(item_q.read_index) < CMPW'(count_q));
		sts.upd_same = (upd == rdata_q.events);
		sts.upd_drop = (upd == '0) || (upd == spdt_pkg::FORCED_BITS);
	end

	assign rsp_data = rsp_q;

endmodule

// ===== design/spdt_ctrl.sv =====
module spdt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  spdt_pkg::sts_t   sts,
	output spdt_pkg::cmd_t   cmd
);

	spdt_pkg::state_t state_q;
	spdt_pkg::state_t state_nx;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			spdt_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_nx = spdt_pkg::ST_DISPATCH;
				end
			end
			spdt_pkg::ST_DISPATCH: begin
				unique case (sts.op)
					spdt_pkg::OP_CLEAR: state_nx = spdt_pkg::ST_FINISH;
					spdt_pkg::OP_READ: begin
						state_nx = sts.read_ok ? spdt_pkg::ST_READ_WAIT : spdt_pkg::ST_FINISH;
					end
					default: begin
						if (sts.op == spdt_pkg::OP_ACTIVATE && sts.mask_zero && sts.merge) begin
							state_nx = spdt_pkg::ST_FINISH;
						end else if (sts.count_zero) begin
							state_nx = spdt_pkg::ST_NOTFOUND;
						end else begin
							state_nx = spdt_pkg::ST_SRCH_RD;
						end
					end
				endcase
			end
			spdt_pkg::ST_SRCH_RD: state_nx = spdt_pkg::ST_SRCH_CMP;
			spdt_pkg::ST_SRCH_CMP: begin
				if (sts.hit_lt) begin
					state_nx = sts.ptr_last ? spdt_pkg::ST_NOTFOUND : spdt_pkg::ST_SRCH_RD;
				end else begin
					state_nx = sts.hit_eq ? spdt_pkg::ST_FOUND : spdt_pkg::ST_NOTFOUND;
				end
			end
			spdt_pkg::ST_NOTFOUND: begin
				if (sts.op == spdt_pkg::OP_ACTIVATE && !sts.mask_zero && !sts.count_full) begin
					state_nx = spdt_pkg::ST_INS_CHK;
				end else begin
					state_nx = spdt_pkg::ST_FINISH;
				end
			end
			spdt_pkg::ST_FOUND: begin
				if (!(sts.op == spdt_pkg::OP_ACTIVATE && !sts.mask_zero) && sts.upd_drop) begin
					state_nx = spdt_pkg::ST_REM_CHK;
				end else begin
					state_nx = spdt_pkg::ST_FINISH;
				end
			end
			spdt_pkg::ST_INS_CHK: begin
				state_nx = sts.ptr_gt_pos ? spdt_pkg::ST_INS_MV : spdt_pkg::ST_FINISH;
			end
			spdt_pkg::ST_INS_MV: state_nx = spdt_pkg::ST_INS_CHK;
			spdt_pkg::ST_REM_CHK: begin
				state_nx = sts.ptr_last ? spdt_pkg::ST_FINISH : spdt_pkg::ST_REM_MV;
			end
			spdt_pkg::ST_REM_MV: state_nx = spdt_pkg::ST_REM_CHK;
			spdt_pkg::ST_READ_WAIT: state_nx = spdt_pkg::ST_FINISH;
			spdt_pkg::ST_FINISH: begin
				if (slot_free) begin
					state_nx = spdt_pkg::ST_IDLE;
				end
			end
			default: state_nx = spdt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = spdt_pkg::RD_PTR;
		cmd.wr_sel = spdt_pkg::WR_SHIFT;
		req_ready = 1'b0;
		unique case (state_q)
			spdt_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load = req_valid;
			end
			spdt_pkg::ST_DISPATCH: begin
				unique case (sts.op)
					spdt_pkg::OP_CLEAR: begin
						cmd.count_clear = 1'b1;
						cmd.res_set = 1'b1;
						cmd.res_changed = 1'b1;
					end
					spdt_pkg::OP_READ: begin
						if (sts.read_ok) begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = spdt_pkg::RD_IDX;
						end else begin
							cmd.res_set = 1'b1;
						end
					end
					default: begin
						if (sts.op == spdt_pkg::OP_ACTIVATE && sts.mask_zero && sts.merge) begin
							cmd.res_set = 1'b1;
							cmd.res_changed = 1'b1;
						end else if (sts.count_zero) begin
							cmd.pos_from_count = 1'b1;
						end else begin
							cmd.ptr_zero = 1'b1;
						end
					end
				endcase
			end
			spdt_pkg::ST_SRCH_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = spdt_pkg::RD_PTR;
			end
			spdt_pkg::ST_SRCH_CMP: begin
				if (sts.hit_lt) begin
					if (sts.ptr_last) begin
						cmd.pos_from_count = 1'b1;
					end else begin
						cmd.ptr_inc = 1'b1;
					end
				end else begin
					cmd.pos_from_ptr = 1'b1;
				end
			end
			spdt_pkg::ST_NOTFOUND: begin
				if (sts.op == spdt_pkg::OP_DEACTIVATE) begin
					cmd.res_set = 1'b1;
				end else if (sts.mask_zero) begin
					cmd.res_set = 1'b1;
					cmd.res_changed = 1'b1;
				end else if (sts.count_full) begin
					cmd.res_set = 1'b1;
					cmd.res_full = 1'b1;
				end else begin
					cmd.ptr_from_count = 1'b1;
				end
			end
			spdt_pkg::ST_FOUND: begin
				if (sts.op == spdt_pkg::OP_ACTIVATE && !sts.mask_zero) begin
					cmd.res_set = 1'b1;
					cmd.res_changed = !sts.upd_same;
					cmd.wr_en = !sts.upd_same;
					cmd.wr_sel = spdt_pkg::WR_EVENTS;
				end else if (sts.upd_drop) begin
					cmd.ptr_from_pos = 1'b1;
				end else begin
					cmd.res_set = 1'b1;
					cmd.res_changed = 1'b1;
					cmd.wr_en = 1'b1;
					cmd.wr_sel = spdt_pkg::WR_EVENTS;
				end
			end
			spdt_pkg::ST_INS_CHK: begin
				if (sts.ptr_gt_pos) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = spdt_pkg::RD_PTR_DEC;
				end else begin
					cmd.wr_en = 1'b1;
					cmd.wr_sel = spdt_pkg::WR_NEW;
					cmd.count_inc = 1'b1;
					cmd.res_set = 1'b1;
					cmd.res_changed = 1'b1;
				end
			end
			spdt_pkg::ST_INS_MV: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = spdt_pkg::WR_SHIFT;
				cmd.ptr_dec = 1'b1;
			end
			spdt_pkg::ST_REM_CHK: begin
				if (sts.ptr_last) begin
					cmd.count_dec = 1'b1;
					cmd.res_set = 1'b1;
					cmd.res_changed = 1'b1;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = spdt_pkg::RD_PTR_INC;
				end
			end
			spdt_pkg::ST_REM_MV: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = spdt_pkg::WR_SHIFT;
				cmd.ptr_inc = 1'b1;
			end
			spdt_pkg::ST_READ_WAIT: begin
				cmd.res_set = 1'b1;
				cmd.res_changed = 1'b1;
				cmd.res_valid = 1'b1;
			end
			spdt_pkg::ST_FINISH: begin
				cmd.push = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spdt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

// ===== design/sorted_poll_descriptor_table_unit.sv =====
// Clear, a read past the count and a zero-mask merge go from dispatch straight to the
// result; a read first waits on its slot read; activate and deactivate read and compare
// entries one by one, then shift entries one at a time. Throughput: one item at a time;
// the next beat is accepted the cycle after the result is loaded; a waiting result holds
// the block until taken. Reset: clears the entry count, the controller state and the
// output valid; slot contents and the output payload are left as is, with no clearing pass.
module sorted_poll_descriptor_table_unit #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  spdt_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output spdt_pkg::rsp_t rsp_data
);

	spdt_pkg::cmd_t cmd;
	spdt_pkg::sts_t sts;

	spdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	spdt_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req_data),
		.sts      (sts),
		.rsp_data (rsp_data)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_inc |-> !sts.count_full)
		else $error("insert into a full table");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_dec |-> !sts.count_zero)
		else $error("remove from an empty table");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.table_full && rsp_data.changed))
		else $error("full flag with a change");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_data.entry_valid) |->
		(rsp_data.entry_descriptor == '0 && rsp_data.entry_events == '0))
		else $error("entry data on a beat without a valid entry");

endmodule

// ===== verif/sorted_poll_descriptor_table_unit_tb.sv =====
module sorted_poll_descriptor_table_unit_tb;

	localparam int CAPACITY = 64;
	localparam logic [spdt_pkg::MASK_W-1:0] ALL_EVENTS = '1;

	typedef struct {
		logic           pause;
		spdt_pkg::req_t req;
	} backlog_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	spdt_pkg::req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	spdt_pkg::rsp_t rsp_data;

	backlog_t op_backlog[$];
	spdt_pkg::rsp_t table_outcomes[$];
	backlog_t next_beat;
	spdt_pkg::rsp_t oldest_outcome;

	logic [spdt_pkg::DESC_W-1:0] slot_desc [CAPACITY];
	logic [spdt_pkg::MASK_W-1:0] slot_events [CAPACITY];
	int slot_count = 0;

	int queued_items = 0;
	int beats_sent = 0;
	int quiet_from = 1 << 30;
	int send_gap = 0;
	int recv_stall = 0;
	int mismatches = 0;
	int op_tally [4] = '{0, 0, 0, 0};
	int full_refusals = 0;
	int peak_count = 0;
	logic quiet_tail;

	assign quiet_tail = beats_sent >= quiet_from;

	sorted_poll_descriptor_table_unit #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int find_slot(input logic [spdt_pkg::DESC_W-1:0] d);
		int i = 0;
		while (i < slot_count && slot_desc[i] < d)
			i++;
		return i;
	endfunction

	function automatic void remove_slot(input int pos);
		int i;
		for (i = pos; i + 1 < slot_count; i++) begin
			slot_desc[i] = slot_desc[i + 1];
			slot_events[i] = slot_events[i + 1];
		end
		if (slot_count > 0)
			slot_count--;
	endfunction

	function automatic logic deactivate_desc(input logic [spdt_pkg::DESC_W-1:0] d,
			input logic [spdt_pkg::MASK_W-1:0] m);
		int pos;
		logic [spdt_pkg::MASK_W-1:0] ev;
		if (slot_count == 0)
			return 1'b0;
		pos = find_slot(d);
		if (pos >= slot_count || slot_desc[pos] != d)
			return 1'b0;
		ev = slot_events[pos] & ~m;
		slot_events[pos] = ev;
		if (ev == '0 || ev == spdt_pkg::FORCED_BITS)
			remove_slot(pos);
		return 1'b1;
	endfunction

	function automatic logic activate_desc(input logic [spdt_pkg::DESC_W-1:0] d,
			input logic [spdt_pkg::MASK_W-1:0] m, input logic mg, output logic full);
		int pos;
		int i;
		logic [spdt_pkg::MASK_W-1:0] ev;
		logic [spdt_pkg::MASK_W-1:0] nev;
		full = 1'b0;
		if (m == '0) begin
			if (!mg)
				void'(deactivate_desc(d, ALL_EVENTS));
			return 1'b1;
		end
		ev = m | spdt_pkg::FORCED_BITS;
		pos = find_slot(d);
		if (pos < slot_count && slot_desc[pos] == d) begin
			nev = mg ? (slot_events[pos] | ev) : ev;
			if (nev == slot_events[pos])
				return 1'b0;
			slot_events[pos] = nev;
			return 1'b1;
		end
		if (slot_count >= CAPACITY) begin
			full = 1'b1;
			return 1'b0;
		end
		for (i = slot_count; i > pos; i--) begin
			slot_desc[i] = slot_desc[i - 1];
			slot_events[i] = slot_events[i - 1];
		end
		slot_desc[pos] = d;
		slot_events[pos] = ev;
		slot_count++;
		return 1'b1;
	endfunction

	task automatic apply_table_op(input spdt_pkg::req_t r);
		spdt_pkg::rsp_t o;
		logic full;
		o = '0;
		full = 1'b0;
		case (r.operation)
			spdt_pkg::OP_ACTIVATE: begin
				o.changed = activate_desc(r.descriptor, r.event_mask, r.merge, full);
			end
			spdt_pkg::OP_DEACTIVATE: begin
				o.changed = deactivate_desc(r.descriptor, r.event_mask);
			end
			spdt_pkg::OP_CLEAR: begin
				slot_count = 0;
				o.changed = 1'b1;
			end
			default: begin
				if (int'(r.read_index) < slot_count) begin
					o.entry_valid = 1'b1;
					o.entry_descriptor = slot_desc[r.read_index];
					o.entry_events = slot_events[r.read_index];
					o.changed = 1'b1;
				end
			end
		endcase
		o.table_full = full;
		o.active_count = 7'(slot_count);
		op_tally[r.operation]++;
		if (full)
			full_refusals++;
		if (slot_count > peak_count)
			peak_count = slot_count;
		table_outcomes.insert(table_outcomes.size(), o);
	endtask

	task automatic compare_outcome(input spdt_pkg::rsp_t got, input spdt_pkg::rsp_t want);
		if (got.changed !== want.changed) begin
			$error("changed: expected %0h, got %0h", want.changed, got.changed);
			mismatches++;
		end
		if (got.table_full !== want.table_full) begin
			$error("table_full: expected %0h, got %0h", want.table_full, got.table_full);
			mismatches++;
		end
		if (got.active_count !== want.active_count) begin
			$error("active_count: expected %0d, got %0d", want.active_count,
				got.active_count);
			mismatches++;
		end
		if (got.entry_valid !== want.entry_valid) begin
			$error("entry_valid: expected %0h, got %0h", want.entry_valid, got.entry_valid);
			mismatches++;
		end
		if (got.entry_descriptor !== want.entry_descriptor) begin
			$error("entry_descriptor: expected %h, got %h", want.entry_descriptor,
				got.entry_descriptor);
			mismatches++;
		end
		if (got.entry_events !== want.entry_events) begin
			$error("entry_events: expected %h, got %h", want.entry_events,
				got.entry_events);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
			send_gap <= 0;
		end else begin
			if (req_valid && req_ready) begin
				apply_table_op(req_data);
				beats_sent <= beats_sent + 1;
			end
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					req_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (op_backlog.size() == 0) begin
					req_valid <= 1'b0;
				end else if (op_backlog[0].pause) begin
					// hold until every outstanding result is back
					req_valid <= 1'b0;
					if (table_outcomes.size() == 0)
						void'(op_backlog.pop_front());
				end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
					req_valid <= 1'b0;
					send_gap <= $urandom_range(0, 13);
				end else begin
					next_beat = op_backlog.pop_front();
					req_valid <= 1'b1;
					req_data <= next_beat.req;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (table_outcomes.size() == 0) begin
					$error("response beat with no request outstanding");
					mismatches++;
				end else begin
					oldest_outcome = table_outcomes.pop_front();
					compare_outcome(rsp_data, oldest_outcome);
				end
			end
			if (recv_stall > 0) begin
				rsp_ready <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				recv_stall <= $urandom_range(0, 13);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	task automatic queue_op(input spdt_pkg::op_t op, input logic [spdt_pkg::DESC_W-1:0] d,
			input logic [spdt_pkg::MASK_W-1:0] m, input logic mg,
			input logic [spdt_pkg::IDX_W-1:0] idx);
		backlog_t b;
		b.pause = 1'b0;
		b.req.operation = op;
		b.req.descriptor = d;
		b.req.event_mask = m;
		b.req.merge = mg;
		b.req.read_index = idx;
		op_backlog.insert(op_backlog.size(), b);
		queued_items++;
	endtask

	task automatic queue_pause();
		backlog_t b;
		b.pause = 1'b1;
		b.req = '0;
		op_backlog.insert(op_backlog.size(), b);
	endtask

	function automatic logic [spdt_pkg::MASK_W-1:0] activate_mask();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return '0;
		if (pick < 3)
			return 16'(1) << $urandom_range(0, 15);
		return 16'($urandom());
	endfunction

	task automatic queue_fill_phase();
		logic [spdt_pkg::DESC_W-1:0] descs [CAPACITY];
		int order [CAPACITY];
		int i;
		int j;
		int tmp;
		int extra;
		queue_op(spdt_pkg::OP_CLEAR, 16'($urandom()), 16'($urandom()),
			1'($urandom_range(0, 1)), 6'($urandom()));
		for (i = 0; i < CAPACITY; i++) begin
			descs[i] = {6'(i), 10'($urandom_range(0, 1023))};
			order[i] = i;
		end
		for (i = CAPACITY - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		// insert in shuffled order so every position sees an insertion
		for (i = 0; i < CAPACITY; i++)
			queue_op(spdt_pkg::OP_ACTIVATE, descs[order[i]], 16'($urandom_range(1, 65535)),
				1'($urandom_range(0, 1)), 6'($urandom()));
		extra = $urandom_range(3, 6);
		for (i = 0; i < extra; i++) begin
			j = $urandom_range(0, CAPACITY - 1);
			queue_op(spdt_pkg::OP_ACTIVATE, descs[j] ^ 16'($urandom_range(1, 1023)),
				16'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)), 6'($urandom()));
			queue_op(spdt_pkg::OP_ACTIVATE, descs[$urandom_range(0, CAPACITY - 1)],
				activate_mask(), 1'b1, 6'($urandom()));
		end
		queue_op(spdt_pkg::OP_READ, 16'($urandom()), 16'($urandom()), 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_READ, 16'($urandom()), 16'($urandom()), 1'b1, 6'd63);
		for (i = 0; i < 10; i++)
			queue_op(spdt_pkg::OP_READ, 16'($urandom()), 16'($urandom()),
				1'($urandom_range(0, 1)), 6'($urandom()));
		for (i = 0; i < 24; i++) begin
			j = $urandom_range(0, CAPACITY - 1);
			case ($urandom_range(0, 2))
				0: queue_op(spdt_pkg::OP_DEACTIVATE, descs[j], ALL_EVENTS,
					1'($urandom_range(0, 1)), 6'($urandom()));
				1: queue_op(spdt_pkg::OP_DEACTIVATE, descs[j], ~spdt_pkg::FORCED_BITS,
					1'($urandom_range(0, 1)), 6'($urandom()));
				default: queue_op(spdt_pkg::OP_DEACTIVATE, descs[j], 16'($urandom()),
					1'($urandom_range(0, 1)), 6'($urandom()));
			endcase
		end
		for (i = 0; i < 4; i++)
			queue_op(spdt_pkg::OP_ACTIVATE,
				descs[$urandom_range(0, CAPACITY - 1)] ^ 16'(i + 1),
				16'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)), 6'($urandom()));
		for (i = 0; i < 6; i++)
			queue_op(spdt_pkg::OP_READ, 16'($urandom()), 16'($urandom()),
				1'($urandom_range(0, 1)), 6'($urandom()));
	endtask

	task automatic queue_churn_phase();
		logic [spdt_pkg::DESC_W-1:0] pool [40];
		logic [spdt_pkg::DESC_W-1:0] base;
		logic [spdt_pkg::DESC_W-1:0] step;
		logic [spdt_pkg::DESC_W-1:0] d;
		logic [spdt_pkg::MASK_W-1:0] m;
		int n;
		int len;
		int k;
		int r;
		n = $urandom_range(4, 40);
		base = 16'($urandom());
		step = 16'($urandom_range(1, 300));
		for (k = 0; k < n; k++)
			pool[k] = base + 16'(k) * step;
		len = $urandom_range(15, 45);
		for (k = 0; k < len; k++) begin
			d = pool[$urandom_range(0, n - 1)];
			r = $urandom_range(0, 99);
			if (r < 45) begin
				queue_op(spdt_pkg::OP_ACTIVATE, d, activate_mask(), 1'($urandom_range(0, 1)),
					6'($urandom()));
			end else if (r < 70) begin
				case ($urandom_range(0, 3))
					0: m = ALL_EVENTS;
					1: m = 16'(1) << $urandom_range(0, 15);
					2: m = 16'($urandom());
					default: m = ~spdt_pkg::FORCED_BITS;
				endcase
				queue_op(spdt_pkg::OP_DEACTIVATE, d, m, 1'($urandom_range(0, 1)),
					6'($urandom()));
			end else if (r < 92) begin
				queue_op(spdt_pkg::OP_READ, 16'($urandom()), 16'($urandom()),
					1'($urandom_range(0, 1)),
					6'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 63)));
			end else if (r < 94) begin
				queue_op(spdt_pkg::OP_CLEAR, d, 16'($urandom()), 1'($urandom_range(0, 1)),
					6'($urandom()));
			end else begin
				queue_op(spdt_pkg::op_t'($urandom_range(0, 3)), 16'($urandom()),
					16'($urandom()), 1'($urandom_range(0, 1)), 6'($urandom()));
			end
		end
		if ($urandom_range(0, 4) == 0)
			queue_pause();
	endtask

	initial begin
		queue_op(spdt_pkg::OP_READ, 16'h0000, 16'h0000, 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_DEACTIVATE, 16'h0000, ALL_EVENTS, 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_ACTIVATE, 16'h8000, 16'h0001, 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_ACTIVATE, 16'h0000, ALL_EVENTS, 1'b1, 6'd63);
		queue_op(spdt_pkg::OP_ACTIVATE, 16'hFFFF, 16'h0100, 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_ACTIVATE, 16'h8000, 16'h0001, 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_ACTIVATE, 16'h8000, 16'h0002, 1'b1, 6'd0);
		queue_op(spdt_pkg::OP_ACTIVATE, 16'h8000, 16'h0002, 1'b1, 6'd0);
		queue_op(spdt_pkg::OP_ACTIVATE, 16'h8000, 16'h0000, 1'b1, 6'd0);
		queue_op(spdt_pkg::OP_DEACTIVATE, 16'h1234, ALL_EVENTS, 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_DEACTIVATE, 16'h8000, 16'h0001, 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_DEACTIVATE, 16'h8000, 16'h0002, 1'b1, 6'd0);
		queue_op(spdt_pkg::OP_ACTIVATE, 16'hFFFF, 16'h0000, 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_ACTIVATE, 16'h4444, 16'h0000, 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_READ, 16'hFFFF, ALL_EVENTS, 1'b1, 6'd0);
		queue_op(spdt_pkg::OP_READ, 16'h0000, 16'h0000, 1'b0, 6'd1);
		queue_op(spdt_pkg::OP_READ, 16'h0000, 16'h0000, 1'b0, 6'd63);
		queue_op(spdt_pkg::OP_DEACTIVATE, 16'h0000, spdt_pkg::FORCED_BITS, 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_READ, 16'h0000, 16'h0000, 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_DEACTIVATE, 16'h0000, ALL_EVENTS, 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_CLEAR, 16'h0000, 16'h0000, 1'b0, 6'd0);
		queue_op(spdt_pkg::OP_READ, 16'h0000, 16'h0000, 1'b0, 6'd0);
		queue_pause();
		queue_fill_phase();
		while (queued_items < 780) begin
			if ($urandom_range(0, 7) == 0)
				queue_fill_phase();
			else
				queue_churn_phase();
		end
		quiet_from = queued_items - 80;

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (op_backlog.size() != 0 || req_valid)
			@(posedge clk);
		while (table_outcomes.size() != 0)
			@(posedge clk);
		repeat (4 * CAPACITY + 20) @(posedge clk);

		$display("Run covered %0d requests: %0d activate, %0d deactivate, %0d clear, %0d read.",
			beats_sent, op_tally[spdt_pkg::OP_ACTIVATE], op_tally[spdt_pkg::OP_DEACTIVATE],
			op_tally[spdt_pkg::OP_CLEAR], op_tally[spdt_pkg::OP_READ]);
		$display("Occupancy peaked at %0d of %0d slots; %0d inserts refused on a full table.",
			peak_count, CAPACITY, full_refusals);
		if (mismatches == 0 && table_outcomes.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#15000000;
		$display("Verification failed");
		$finish;
	end

endmodule
